// ----- hw/rtl/tcw_pkg.sv -----
// Package for the text console writer: screen geometry, command codes and the
// structs passed between the sequencer, the cell RAM and the result queue.
// No dependencies.
package tcw_pkg;

  localparam int COLS       = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  // Field widths fixed by the port definition
  localparam int MODE_W = 3;
  localparam int CHAR_W = 8;
  localparam int CLR_W  = 4;
  localparam int POS_W  = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 16;

  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;

  localparam logic [MODE_W-1:0] MODE_PUT_CHAR   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_NEWLINE    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BACKSPACE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ       = 3'd4;
  localparam logic [MODE_W-1:0] MODE_PLOT       = 3'd5;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_MODIFY,
    ST_SWEEP
  } seq_state_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CHAR_W-1:0] character;
    logic [CLR_W-1:0]  fg_color;
    logic              keep_fg;
    logic [CLR_W-1:0]  bg_color;
    logic              keep_bg;
    logic [POS_W-1:0]  col;
    logic [POS_W-1:0]  row;
  } cmd_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col_out;
    logic [ROW_W-1:0]  cursor_row_out;
    logic [CELL_W-1:0] cell_word;
    logic              scrolled;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

// ----- hw/rtl/tcw_cmd_if.sv -----
// Command channel of the text console writer: valid/ready plus one command word.
// Depends on tcw_pkg.
interface tcw_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [tcw_pkg::MODE_W-1:0]        mode;
  logic [tcw_pkg::CHAR_W-1:0]        character;
  logic [tcw_pkg::CLR_W-1:0]         fg_color;
  logic                              keep_fg;
  logic [tcw_pkg::CLR_W-1:0]         bg_color;
  logic                              keep_bg;
  logic [tcw_pkg::POS_W-1:0]         col;
  logic [tcw_pkg::POS_W-1:0]         row;

  modport source (
    output valid, mode, character, fg_color, keep_fg, bg_color, keep_bg, col, row,
    input  ready
  );
  modport sink (
    input  valid, mode, character, fg_color, keep_fg, bg_color, keep_bg, col, row,
    output ready
  );
endinterface

// ----- hw/rtl/tcw_res_if.sv -----
// Result channel of the text console writer: valid/ready plus one result word.
// Depends on tcw_pkg.
interface tcw_res_if;
  logic                       valid;
  logic                       ready;
  logic [tcw_pkg::COL_W-1:0]  cursor_col_out;
  logic [tcw_pkg::ROW_W-1:0]  cursor_row_out;
  logic [tcw_pkg::CELL_W-1:0] cell_word;
  logic                       scrolled;

  modport source (
    output valid, cursor_col_out, cursor_row_out, cell_word, scrolled,
    input  ready
  );
  modport sink (
    input  valid, cursor_col_out, cursor_row_out, cell_word, scrolled,
    output ready
  );
endinterface

// ----- hw/rtl/text_console_writer_core.sv -----
// Top level of the text console writer: sequencer, cell RAM and result queue.
// Depends on tcw_pkg, tcw_cmd_if, tcw_res_if, tcw_seq, tcw_cell_ram, tcw_res_q.

// Text console writer. The 80x25 screen of 16-bit cells sits in one RAM with a
// single write and a single registered read port, and every command goes
// through that port pair. After reset the block clears the RAM, one cell a
// cycle, before it takes its first command. Put_char, plot, backspace, read,
// newline and the unused codes read the cell when accepted and then, in the
// modify state, write it back where the command changes it. A line break on
// the last row, direct or from a put_char wrap, adds a scroll sweep; clear is
// accepted and then runs a sweep. One command is in work at a time; up to two
// results queue at the output, so a new command is taken while an earlier
// result waits.
module text_console_writer_core (
  input  logic      clk,
  input  logic      rst,
  tcw_cmd_if.sink   cmd,
  tcw_res_if.source res
);

  tcw_pkg::ram_req_t          ram_req;
  logic [tcw_pkg::CELL_W-1:0] rdata;
  tcw_pkg::res_t              fin_res;
  logic                       fin;
  logic                       q_full;

  tcw_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .q_full  (q_full),
    .fin     (fin),
    .fin_res (fin_res),
    .ram_req (ram_req),
    .rdata   (rdata)
  );

  tcw_cell_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (rdata)
  );

  tcw_res_q u_q (
    .clk      (clk),
    .rst      (rst),
    .push     (fin),
    .push_res (fin_res),
    .full     (q_full),
    .res      (res)
  );

endmodule

// ----- hw/rtl/tcw_cell_ram.sv -----
// Screen cell store: one write port, one read port, registered read data.
// Depends on tcw_pkg.
module tcw_cell_ram (
  input  logic                       clk,
  input  tcw_pkg::ram_req_t          req,
  output logic [tcw_pkg::CELL_W-1:0] rdata
);

  logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELL_COUNT];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// ----- hw/rtl/tcw_seq.sv -----
// Command sequencer: cursor, cell read-modify-write, scroll and clear sweeps,
// and the clearing pass after reset. Depends on tcw_pkg and tcw_cmd_if.
module tcw_seq (
  input  logic                       clk,
  input  logic                       rst,
  tcw_cmd_if.sink                    cmd,
  input  logic                       q_full,
  output logic                       fin,
  output tcw_pkg::res_t              fin_res,
  output tcw_pkg::ram_req_t          ram_req,
  input  logic [tcw_pkg::CELL_W-1:0] rdata
);

  localparam logic [tcw_pkg::ADDR_W-1:0] LAST_CELL   = tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1);
  localparam logic [tcw_pkg::ADDR_W-1:0] BOTTOM_BASE =
    tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - tcw_pkg::COLS);
  localparam logic [tcw_pkg::ADDR_W-1:0] ROW_STRIDE  = tcw_pkg::ADDR_W'(tcw_pkg::COLS);
  localparam logic [tcw_pkg::COL_W-1:0]  LAST_COL    = tcw_pkg::COL_W'(tcw_pkg::COLS - 1);
  localparam logic [tcw_pkg::ROW_W-1:0]  LAST_ROW    = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);

  tcw_pkg::seq_state_t state, state_next;
  tcw_pkg::cmd_t       in_cmd, cmd_r;

  logic [tcw_pkg::COL_W-1:0]  cur_col, col_next, bs_col, pos_col, sel_col;
  logic [tcw_pkg::ROW_W-1:0]  cur_row, row_next, bs_row, pos_row, sel_row;
  logic [tcw_pkg::ADDR_W-1:0] acc_addr, addr_r, rd_cnt, wr_addr, sweep_src;
  logic [tcw_pkg::CELL_W-1:0] mod_data, sweep_data;
  logic                       accept, at_home, brk, last_row, scroll_go, sweep_done;
  logic                       scr, wr_cell, rd_on, wr_on, is_clear;

  assign in_cmd = '{mode: cmd.mode, character: cmd.character, fg_color: cmd.fg_color,
                    keep_fg: cmd.keep_fg, bg_color: cmd.bg_color, keep_bg: cmd.keep_bg,
                    col: cmd.col, row: cmd.row};

  assign cmd.ready = (state == tcw_pkg::ST_IDLE) && !q_full;
  assign accept    = cmd.valid && cmd.ready;

  // Position for plot/read, clamped to the last column and row
  assign pos_col = (cmd.col >= tcw_pkg::POS_W'(tcw_pkg::COLS)) ? LAST_COL
                                                               : cmd.col[tcw_pkg::COL_W-1:0];
  assign pos_row = (cmd.row >= tcw_pkg::POS_W'(tcw_pkg::ROWS)) ? LAST_ROW
                                                               : cmd.row[tcw_pkg::ROW_W-1:0];

  assign at_home = (cur_col == '0) && (cur_row == '0);
  assign bs_col  = (cur_col == '0) ? LAST_COL : cur_col - 1'b1;
  assign bs_row  = (cur_col == '0) ? cur_row - 1'b1 : cur_row;

  always_comb begin
    unique case (cmd.mode) inside
      tcw_pkg::MODE_BACKSPACE: begin
        sel_col = bs_col;
        sel_row = bs_row;
      end
      tcw_pkg::MODE_READ, tcw_pkg::MODE_PLOT: begin
        sel_col = pos_col;
        sel_row = pos_row;
      end
      default: begin
        sel_col = cur_col;
        sel_row = cur_row;
      end
    endcase
  end

  assign acc_addr = tcw_pkg::ADDR_W'(sel_col) + tcw_pkg::ADDR_W'(sel_row) * ROW_STRIDE;

  // Cell modify for put_char/plot/backspace
  assign mod_data = (cmd_r.mode == tcw_pkg::MODE_BACKSPACE)
                  ? {rdata[15:8], tcw_pkg::BLANK_CHAR}
                  : {cmd_r.keep_bg ? rdata[15:12] : cmd_r.bg_color,
                     cmd_r.keep_fg ? rdata[11:8]  : cmd_r.fg_color,
                     cmd_r.character};

  assign brk      = (cmd_r.mode == tcw_pkg::MODE_NEWLINE) ||
                    ((cmd_r.mode == tcw_pkg::MODE_PUT_CHAR) && (cur_col == LAST_COL));
  assign last_row = (cur_row == LAST_ROW);

  // Sweep: read the source for rd_cnt, write destination rd_cnt in the following cycle
  assign is_clear  = (cmd_r.mode == tcw_pkg::MODE_CLEAR);
  assign sweep_src = (!is_clear && rd_cnt < BOTTOM_BASE) ? rd_cnt + ROW_STRIDE : rd_cnt;
  always_comb begin
    if (is_clear) begin
      sweep_data = {cmd_r.keep_bg ? rdata[15:12] : cmd_r.bg_color, rdata[11:8],
                    tcw_pkg::BLANK_CHAR};
    end else if (wr_addr >= BOTTOM_BASE) begin
      sweep_data = {rdata[15:8], tcw_pkg::BLANK_CHAR};
    end else begin
      sweep_data = rdata;
    end
  end
  assign sweep_done = wr_on && !rd_on;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      tcw_pkg::ST_INIT: begin
        if (rd_cnt == LAST_CELL) state_next = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (cmd.mode == tcw_pkg::MODE_CLEAR) ? tcw_pkg::ST_SWEEP
                                                         : tcw_pkg::ST_MODIFY;
        end
      end
      tcw_pkg::ST_MODIFY: begin
        state_next = scroll_go ? tcw_pkg::ST_SWEEP : tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_SWEEP: begin
        if (sweep_done) state_next = tcw_pkg::ST_IDLE;
      end
      default: state_next = tcw_pkg::ST_IDLE;
    endcase
  end

  // Outputs: RAM port, cursor update, finish
  always_comb begin
    ram_req   = '0;
    fin       = 1'b0;
    scroll_go = 1'b0;
    col_next  = cur_col;
    row_next  = cur_row;
    unique case (state)
      tcw_pkg::ST_INIT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = rd_cnt;
        ram_req.wdata = '0;
      end
      tcw_pkg::ST_IDLE: begin
        ram_req.re    = accept;
        ram_req.raddr = acc_addr;
      end
      tcw_pkg::ST_MODIFY: begin
        ram_req.we    = wr_cell;
        ram_req.waddr = addr_r;
        ram_req.wdata = mod_data;
        if (brk) begin
          col_next = '0;
          if (!last_row) row_next = cur_row + 1'b1;
        end else if (cmd_r.mode == tcw_pkg::MODE_PUT_CHAR) begin
          col_next = cur_col + 1'b1;
        end
        scroll_go = brk && last_row;
        fin       = !scroll_go;
      end
      tcw_pkg::ST_SWEEP: begin
        ram_req.re    = rd_on;
        ram_req.raddr = sweep_src;
        ram_req.we    = wr_on;
        ram_req.waddr = wr_addr;
        ram_req.wdata = sweep_data;
        fin           = sweep_done;
      end
      default: ;
    endcase
    fin_res.cursor_col_out = col_next;
    fin_res.cursor_row_out = row_next;
    fin_res.cell_word      = (state == tcw_pkg::ST_MODIFY && cmd_r.mode == tcw_pkg::MODE_READ)
                           ? rdata : '0;
    fin_res.scrolled       = scr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= tcw_pkg::ST_INIT;
      rd_cnt  <= '0;
      rd_on   <= 1'b0;
      wr_on   <= 1'b0;
      cur_col <= '0;
      cur_row <= '0;
      scr     <= 1'b0;
      wr_cell <= 1'b0;
    end else begin
      state <= state_next;
      if (state == tcw_pkg::ST_INIT) rd_cnt <= rd_cnt + 1'b1;
      if (accept) begin
        scr    <= 1'b0;
        rd_cnt <= '0;
        rd_on  <= (cmd.mode == tcw_pkg::MODE_CLEAR);
        wr_on  <= 1'b0;
        unique case (cmd.mode) inside
          tcw_pkg::MODE_PUT_CHAR, tcw_pkg::MODE_PLOT: wr_cell <= 1'b1;
          tcw_pkg::MODE_BACKSPACE:                    wr_cell <= !at_home;
          default:                                    wr_cell <= 1'b0;
        endcase
        if (cmd.mode == tcw_pkg::MODE_BACKSPACE && !at_home) begin
          cur_col <= bs_col;
          cur_row <= bs_row;
        end
      end
      if (state == tcw_pkg::ST_MODIFY) begin
        cur_col <= col_next;
        cur_row <= row_next;
        if (scroll_go) begin
          scr    <= 1'b1;
          rd_cnt <= '0;
          rd_on  <= 1'b1;
          wr_on  <= 1'b0;
        end
      end
      if (state == tcw_pkg::ST_SWEEP) begin
        wr_on <= rd_on;
        if (rd_on) begin
          rd_cnt <= rd_cnt + 1'b1;
          rd_on  <= (rd_cnt != LAST_CELL);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_cmd;
      addr_r <= acc_addr;
    end
    if (state == tcw_pkg::ST_SWEEP && rd_on) wr_addr <= rd_cnt;
  end

`ifndef SYNTHESIS
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    state == tcw_pkg::ST_IDLE |-> !ram_req.we)
    else $error("cell written while idle");

  a_fin_has_room: assert property (@(posedge clk) disable iff (rst)
    fin |-> !q_full)
    else $error("result finished with queue full");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    cur_col <= LAST_COL && cur_row <= LAST_ROW)
    else $error("cursor off screen");

  a_port_collision: assert property (@(posedge clk) disable iff (rst)
    ram_req.we && ram_req.re |-> ram_req.waddr != ram_req.raddr)
    else $error("sweep read and write hit same cell");

  a_init_full: assert property (@(posedge clk) disable iff (rst)
    state == tcw_pkg::ST_INIT && state_next == tcw_pkg::ST_IDLE |-> rd_cnt == LAST_CELL)
    else $error("clearing pass left early");
`endif

endmodule

// ----- hw/rtl/tcw_res_q.sv -----
// Two-entry result queue between the sequencer and the result channel.
// Depends on tcw_pkg and tcw_res_if.
module tcw_res_q (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tcw_pkg::res_t push_res,
  output logic          full,
  tcw_res_if.source     res
);

  tcw_pkg::res_t slot [2];
  tcw_pkg::res_t head;
  logic          wr_ptr, rd_ptr;
  logic [1:0]    count;
  logic          pop;

  assign head  = slot[rd_ptr];
  assign full  = (count == 2'd2);
  assign pop   = res.valid && res.ready;

  assign res.valid          = (count != 2'd0);
  assign res.cursor_col_out = head.cursor_col_out;
  assign res.cursor_row_out = head.cursor_row_out;
  assign res.cell_word      = head.cell_word;
  assign res.scrolled       = head.scrolled;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_res;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("result queue overflow");

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    $past(!rst && push && !pop) |-> count != 2'd0)
    else $error("pushed word lost");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    !rst && pop && !push |=> count == $past(count) - 2'd1)
    else $error("queue count off after pop");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for text_console_writer_core: directed and random command streams,
// every answer word checked against a behavioral model of the screen and cursor.
// Depends on tcw_pkg, tcw_cmd_if, tcw_res_if and the block's RTL.
module tb_top;

  localparam logic [tcw_pkg::MODE_W-1:0] MODE_UNUSED_LO = 3'd6;
  localparam logic [tcw_pkg::MODE_W-1:0] MODE_UNUSED_HI = 3'd7;
  localparam int RANDOM_ITEMS = 400;
  localparam int TAIL_CYCLES  = 50;
  localparam int CYCLE_LIMIT  = 10_000_000;

  logic clk;
  logic rst;

  tcw_cmd_if cmd_ch ();
  tcw_res_if res_ch ();

  text_console_writer_core dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch)
  );

  // model of the screen and cursor, advanced at each accepted word
  logic [tcw_pkg::CELL_W-1:0] screen_model [tcw_pkg::CELL_COUNT];
  int unsigned                cur_col;
  int unsigned                cur_row;
  tcw_pkg::res_t              console_answers [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int err_count      = 0;
  int sent_count     = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  function automatic int unsigned cell_addr(int unsigned c, int unsigned r);
    if (c >= tcw_pkg::COLS) c = tcw_pkg::COLS - 1;
    if (r >= tcw_pkg::ROWS) r = tcw_pkg::ROWS - 1;
    return c + r * tcw_pkg::COLS;
  endfunction

  function automatic void write_cell(int unsigned idx, logic [tcw_pkg::CHAR_W-1:0] ch,
                                     logic [tcw_pkg::CLR_W-1:0] fg, logic kfg,
                                     logic [tcw_pkg::CLR_W-1:0] bg, logic kbg);
    logic [tcw_pkg::CELL_W-1:0] old;
    old = screen_model[idx];
    if (kfg) fg = old[11:8];
    if (kbg) bg = old[15:12];
    screen_model[idx] = {bg, fg, ch};
  endfunction

  // returns 1 when the screen scrolled
  function automatic logic break_line();
    cur_col = 0;
    if (cur_row + 1 >= tcw_pkg::ROWS) begin
      for (int i = 0; i < tcw_pkg::CELL_COUNT - tcw_pkg::COLS; i++)
        screen_model[i] = screen_model[i + tcw_pkg::COLS];
      // bottom row keeps its colors, only the character is blanked
      for (int c = 0; c < tcw_pkg::COLS; c++)
        screen_model[(tcw_pkg::ROWS - 1) * tcw_pkg::COLS + c][tcw_pkg::CHAR_W-1:0] =
          tcw_pkg::BLANK_CHAR;
      return 1'b1;
    end
    cur_row++;
    return 1'b0;
  endfunction

  function automatic tcw_pkg::res_t console_step(tcw_pkg::cmd_t c);
    tcw_pkg::res_t r;
    r = '0;
    case (c.mode)
      tcw_pkg::MODE_PUT_CHAR: begin
        write_cell(cell_addr(cur_col, cur_row), c.character, c.fg_color, c.keep_fg,
                   c.bg_color, c.keep_bg);
        cur_col++;
        if (cur_col >= tcw_pkg::COLS) r.scrolled = break_line();
      end
      tcw_pkg::MODE_NEWLINE: r.scrolled = break_line();
      tcw_pkg::MODE_BACKSPACE: begin
        if (cur_col != 0 || cur_row != 0) begin
          if (cur_col == 0) begin
            cur_row--;
            cur_col = tcw_pkg::COLS - 1;
          end else begin
            cur_col--;
          end
          write_cell(cell_addr(cur_col, cur_row), tcw_pkg::BLANK_CHAR, '0, 1'b1, '0, 1'b1);
        end
      end
      tcw_pkg::MODE_CLEAR: begin
        for (int i = 0; i < tcw_pkg::CELL_COUNT; i++)
          write_cell(i, tcw_pkg::BLANK_CHAR, '0, 1'b1, c.bg_color, c.keep_bg);
      end
      tcw_pkg::MODE_READ: r.cell_word = screen_model[cell_addr(32'(c.col), 32'(c.row))];
      tcw_pkg::MODE_PLOT: begin
        write_cell(cell_addr(32'(c.col), 32'(c.row)), c.character, c.fg_color, c.keep_fg,
                   c.bg_color, c.keep_bg);
      end
      default: ;
    endcase
    r.cursor_col_out = cur_col[tcw_pkg::COL_W-1:0];
    r.cursor_row_out = cur_row[tcw_pkg::ROW_W-1:0];
    return r;
  endfunction

  function automatic tcw_pkg::cmd_t make_cmd(logic [tcw_pkg::MODE_W-1:0] m,
                                             logic [tcw_pkg::CHAR_W-1:0] ch,
                                             logic [tcw_pkg::CLR_W-1:0] fg, logic kfg,
                                             logic [tcw_pkg::CLR_W-1:0] bg, logic kbg,
                                             logic [tcw_pkg::POS_W-1:0] col,
                                             logic [tcw_pkg::POS_W-1:0] row);
    tcw_pkg::cmd_t c;
    c.mode      = m;
    c.character = ch;
    c.fg_color  = fg;
    c.keep_fg   = kfg;
    c.bg_color  = bg;
    c.keep_bg   = kbg;
    c.col       = col;
    c.row       = row;
    return c;
  endfunction

  function automatic tcw_pkg::cmd_t rand_cmd(logic [tcw_pkg::MODE_W-1:0] m);
    tcw_pkg::cmd_t c;
    c.mode      = m;
    c.character = tcw_pkg::CHAR_W'($urandom_range(255));
    c.fg_color  = tcw_pkg::CLR_W'($urandom_range(15));
    c.keep_fg   = 1'($urandom_range(1));
    c.bg_color  = tcw_pkg::CLR_W'($urandom_range(15));
    c.keep_bg   = 1'($urandom_range(1));
    // mostly on screen, sometimes far past it to hit the clamp
    c.col = ($urandom_range(3) == 0) ? tcw_pkg::POS_W'($urandom_range(255))
                                     : tcw_pkg::POS_W'($urandom_range(tcw_pkg::COLS - 1));
    c.row = ($urandom_range(3) == 0) ? tcw_pkg::POS_W'($urandom_range(255))
                                     : tcw_pkg::POS_W'($urandom_range(tcw_pkg::ROWS - 1));
    return c;
  endfunction

  // call at a falling edge; returns at the falling edge after the word is taken
  task automatic send_cmd(tcw_pkg::cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid = 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid     = 1'b1;
    cmd_ch.mode      = c.mode;
    cmd_ch.character = c.character;
    cmd_ch.fg_color  = c.fg_color;
    cmd_ch.keep_fg   = c.keep_fg;
    cmd_ch.bg_color  = c.bg_color;
    cmd_ch.keep_bg   = c.keep_bg;
    cmd_ch.col       = c.col;
    cmd_ch.row       = c.row;
    @(posedge clk);
    while (cmd_ch.ready !== 1'b1) @(posedge clk);
    console_answers.push_back(console_step(c));
    sent_count++;
    @(negedge clk);
  endtask

  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    tcw_pkg::res_t want;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (console_answers.size() == 0) begin
        $error("unexpected answer word: col %0d row %0d cell %h scrolled %0d",
               res_ch.cursor_col_out, res_ch.cursor_row_out, res_ch.cell_word,
               res_ch.scrolled);
        err_count++;
      end else begin
        want = console_answers.pop_front();
        if (res_ch.cursor_col_out !== want.cursor_col_out) begin
          $error("cursor_col_out: expected %0d, got %0d", want.cursor_col_out,
                 res_ch.cursor_col_out);
          err_count++;
        end
        if (res_ch.cursor_row_out !== want.cursor_row_out) begin
          $error("cursor_row_out: expected %0d, got %0d", want.cursor_row_out,
                 res_ch.cursor_row_out);
          err_count++;
        end
        if (res_ch.cell_word !== want.cell_word) begin
          $error("cell_word: expected %h, got %h", want.cell_word, res_ch.cell_word);
          err_count++;
        end
        if (res_ch.scrolled !== want.scrolled) begin
          $error("scrolled: expected %0d, got %0d", want.scrolled, res_ch.scrolled);
          err_count++;
        end
      end
    end
  end

  task automatic test_reset_state();
    send_cmd(make_cmd(tcw_pkg::MODE_READ, 8'h00, 4'h0, 1'b0, 4'h0, 1'b0, 8'd0, 8'd0));
    send_cmd(make_cmd(tcw_pkg::MODE_READ, 8'h00, 4'h0, 1'b0, 4'h0, 1'b0, 8'd255, 8'd255));
  endtask

  task automatic test_plot_read();
    send_cmd(make_cmd(tcw_pkg::MODE_PLOT, 8'hff, 4'hf, 1'b0, 4'hf, 1'b0, 8'd255, 8'd255));
    send_cmd(make_cmd(tcw_pkg::MODE_READ, 8'h00, 4'h0, 1'b0, 4'h0, 1'b0, 8'd79, 8'd24));
    send_cmd(make_cmd(tcw_pkg::MODE_PLOT, 8'h00, 4'h0, 1'b0, 4'h0, 1'b0, 8'd0, 8'd0));
    // both colors kept from the cell, the passed ones must be ignored
    send_cmd(make_cmd(tcw_pkg::MODE_PLOT, 8'h41, 4'hf, 1'b1, 4'hf, 1'b1, 8'd0, 8'd0));
    send_cmd(make_cmd(tcw_pkg::MODE_READ, 8'hff, 4'hf, 1'b1, 4'hf, 1'b1, 8'd0, 8'd0));
    send_cmd(make_cmd(tcw_pkg::MODE_PLOT, 8'h7e, 4'h9, 1'b1, 4'h6, 1'b0, 8'd200, 8'd3));
    send_cmd(make_cmd(tcw_pkg::MODE_READ, 8'h00, 4'h0, 1'b0, 4'h0, 1'b0, 8'd255, 8'd3));
  endtask

  task automatic test_cursor_moves();
    // backspace at the home position does nothing
    send_cmd(make_cmd(tcw_pkg::MODE_BACKSPACE, 8'h00, 4'h0, 1'b0, 4'h0, 1'b0, 8'd0, 8'd0));
    send_cmd(make_cmd(tcw_pkg::MODE_PUT_CHAR, 8'hff, 4'hf, 1'b0, 4'h0, 1'b0, 8'd0, 8'd0));
    send_cmd(make_cmd(tcw_pkg::MODE_PUT_CHAR, 8'h00, 4'h7, 1'b1, 4'h8, 1'b1, 8'd255, 8'd255));
    send_cmd(make_cmd(tcw_pkg::MODE_PUT_CHAR, 8'h5a, 4'h3, 1'b0, 4'hc, 1'b0, 8'd0, 8'd0));
    send_cmd(make_cmd(tcw_pkg::MODE_BACKSPACE, 8'h00, 4'h0, 1'b0, 4'h0, 1'b0, 8'd0, 8'd0));
    send_cmd(make_cmd(tcw_pkg::MODE_NEWLINE, 8'h00, 4'h0, 1'b0, 4'h0, 1'b0, 8'd0, 8'd0));
    // column 0 of row 1: back to the last column of row 0
    send_cmd(make_cmd(tcw_pkg::MODE_BACKSPACE, 8'h00, 4'h0, 1'b0, 4'h0, 1'b0, 8'd0, 8'd0));
    send_cmd(make_cmd(tcw_pkg::MODE_READ, 8'h00, 4'h0, 1'b0, 4'h0, 1'b0, 8'd79, 8'd0));
    send_cmd(make_cmd(tcw_pkg::MODE_READ, 8'h00, 4'h0, 1'b0, 4'h0, 1'b0, 8'd1, 8'd0));
  endtask

  task automatic test_clear();
    send_cmd(make_cmd(tcw_pkg::MODE_CLEAR, 8'hff, 4'hf, 1'b0, 4'h5, 1'b0, 8'd0, 8'd0));
    send_cmd(make_cmd(tcw_pkg::MODE_READ, 8'h00, 4'h0, 1'b0, 4'h0, 1'b0, 8'd2, 8'd0));
    send_cmd(make_cmd(tcw_pkg::MODE_CLEAR, 8'h00, 4'h0, 1'b1, 4'ha, 1'b1, 8'd0, 8'd0));
    send_cmd(make_cmd(tcw_pkg::MODE_READ, 8'h00, 4'h0, 1'b0, 4'h0, 1'b0, 8'd0, 8'd0));
  endtask

  task automatic test_unused_modes();
    send_cmd(rand_cmd(MODE_UNUSED_LO));
    send_cmd(rand_cmd(MODE_UNUSED_HI));
  endtask

  task automatic test_scroll_wrap();
    tcw_pkg::cmd_t c;
    // walk to the bottom row and scroll twice, then wrap a line on the bottom row
    repeat (tcw_pkg::ROWS + 1) send_cmd(rand_cmd(tcw_pkg::MODE_NEWLINE));
    repeat (tcw_pkg::COLS + 5) send_cmd(rand_cmd(tcw_pkg::MODE_PUT_CHAR));
    for (int i = 0; i < 4; i++) begin
      c = rand_cmd(tcw_pkg::MODE_READ);
      c.row = tcw_pkg::POS_W'(tcw_pkg::ROWS - 2 + i % 2);
      send_cmd(c);
    end
  endtask

  task automatic test_random_traffic(int n);
    int            stop_at;
    int            kind;
    int            len;
    tcw_pkg::cmd_t c;
    stop_at = sent_count + n;
    while (sent_count < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        len = $urandom_range(1, 100);
        repeat (len) send_cmd(rand_cmd(tcw_pkg::MODE_PUT_CHAR));
        if ($urandom_range(1) == 1) send_cmd(rand_cmd(tcw_pkg::MODE_NEWLINE));
      end else if (kind < 50) begin
        len = $urandom_range(1, 8);
        repeat (len) send_cmd(rand_cmd(tcw_pkg::MODE_NEWLINE));
      end else if (kind < 62) begin
        // long runs can climb up to two rows
        len = ($urandom_range(9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 20);
        repeat (len) send_cmd(rand_cmd(tcw_pkg::MODE_BACKSPACE));
      end else if (kind < 80) begin
        c = rand_cmd(tcw_pkg::MODE_PLOT);
        send_cmd(c);
        c.mode = tcw_pkg::MODE_READ;
        send_cmd(c);
        // look at what was typed on the cursor row and the one above
        c = rand_cmd(tcw_pkg::MODE_READ);
        c.row = tcw_pkg::POS_W'(cur_row);
        send_cmd(c);
        c = rand_cmd(tcw_pkg::MODE_READ);
        c.row = (cur_row == 0) ? '0 : tcw_pkg::POS_W'(cur_row - 1);
        send_cmd(c);
      end else if (kind < 83) begin
        send_cmd(rand_cmd(tcw_pkg::MODE_CLEAR));
      end else begin
        len = $urandom_range(1, 5);
        repeat (len) send_cmd(rand_cmd(tcw_pkg::MODE_W'($urandom_range(7))));
      end
    end
  endtask

  initial begin
    rst              = 1'b1;
    cmd_ch.valid     = 1'b0;
    cmd_ch.mode      = tcw_pkg::MODE_PUT_CHAR;
    cmd_ch.character = '0;
    cmd_ch.fg_color  = '0;
    cmd_ch.keep_fg   = 1'b0;
    cmd_ch.bg_color  = '0;
    cmd_ch.keep_bg   = 1'b0;
    cmd_ch.col       = '0;
    cmd_ch.row       = '0;
    for (int i = 0; i < tcw_pkg::CELL_COUNT; i++) screen_model[i] = '0;
    cur_col = 0;
    cur_row = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_plot_read();
    test_cursor_moves();
    test_clear();
    test_unused_modes();
    test_scroll_wrap();

    test_random_traffic(RANDOM_ITEMS / 4);
    send_idle_pct = 85;
    test_random_traffic(RANDOM_ITEMS / 4);
    send_idle_pct  = 0;
    recv_stall_pct = 85;
    test_random_traffic(RANDOM_ITEMS / 4);
    send_idle_pct  = 12;
    recv_stall_pct = 12;
    test_random_traffic(RANDOM_ITEMS / 4);

    cmd_ch.valid = 1'b0;
    while (console_answers.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_cmd_if.sv
hw/rtl/tcw_res_if.sv
hw/rtl/tcw_cell_ram.sv
hw/rtl/tcw_seq.sv
hw/rtl/tcw_res_q.sv
hw/rtl/text_console_writer_core.sv
tb/tb_top.sv
